/* rtl/core/pwi_pkg.sv */
// Shared widths, mode codes, register indexes, operation groups and the multiplier tag type.
`default_nettype none

package pwi_pkg;

  localparam int VEL_W    = 32;
  localparam int NRM_W    = 16;
  localparam int COEF_W   = 16;
  localparam int MUL_A_W  = 41;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] MODE_ESCAPE  = 2'd0;
  localparam logic [1:0] MODE_STICK   = 2'd1;
  localparam logic [1:0] MODE_REBOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION    = 2'd2;

  // Operation groups of the shared multiplier.
  localparam logic [1:0] GRP_DOT  = 2'd0;
  localparam logic [1:0] GRP_PROJ = 2'd1;
  localparam logic [1:0] GRP_REST = 2'd2;
  localparam logic [1:0] GRP_FRIC = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [1:0] grp;
    logic [1:0] lane;
  } mul_tag_t;

endpackage

`default_nettype wire

/* rtl/core/particle_wall_interaction.sv */
// Particle-wall hit resolver: pass, escape, stick or rebound with restitution and friction.
//
//   channel  direction  handshake                 contents
//   in       input      in_valid_i / in_ready_o    one patch hit
//   out      output     out_valid_o / out_ready_i  new velocity, flags, hit totals
//   cfg      input      cfg_we_i                  mode, restitution, friction
//
// A rebound request holds the sequencer while it issues twelve products to the shared
// multiplier: three dot-product terms, a wait for the normal component, nine projection,
// restitution and friction products and a wait for the last product to return. Escape,
// stick and non-wall requests skip the sequencer. The result then goes to the output
// register, and no new request is taken before that load. A stalled output register
// holds the next result back. Reset restores the register defaults and clears the counters.
`default_nettype none

module particle_wall_interaction (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_we_i,
  input  wire logic [pwi_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  wire logic [pwi_pkg::COEF_W-1:0]           cfg_wdata_i,
  input  wire                                       in_valid_i,
  output logic                                      in_ready_o,
  input  wire                                       is_wall_i,
  input  wire                                       active_in_i,
  input  wire logic signed [pwi_pkg::VEL_W-1:0]     vel_x_i,
  input  wire logic signed [pwi_pkg::VEL_W-1:0]     vel_y_i,
  input  wire logic signed [pwi_pkg::VEL_W-1:0]     vel_z_i,
  input  wire logic signed [pwi_pkg::NRM_W-1:0]     normal_x_i,
  input  wire logic signed [pwi_pkg::NRM_W-1:0]     normal_y_i,
  input  wire logic signed [pwi_pkg::NRM_W-1:0]     normal_z_i,
  input  wire logic signed [pwi_pkg::VEL_W-1:0]     wall_vel_x_i,
  input  wire logic signed [pwi_pkg::VEL_W-1:0]     wall_vel_y_i,
  input  wire logic signed [pwi_pkg::VEL_W-1:0]     wall_vel_z_i,
  input  wire                                       clear_counts_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic                                      handled_o,
  output logic                                      keep_particle_o,
  output logic                                      active_out_o,
  output logic signed [pwi_pkg::VEL_W-1:0]          out_vel_x_o,
  output logic signed [pwi_pkg::VEL_W-1:0]          out_vel_y_o,
  output logic signed [pwi_pkg::VEL_W-1:0]          out_vel_z_o,
  output logic [31:0]                               escape_total_o,
  output logic [31:0]                               stick_total_o
);

  localparam int U_W   = 44;
  localparam int NN_W  = 40;
  localparam int DOT_W = 51;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_ESC   = 2'd1;
  localparam logic [1:0] KIND_STICK = 2'd2;
  localparam logic [1:0] KIND_REB   = 2'd3;

  localparam logic [3:0] STEP_LAST = 4'd13;

  function automatic logic signed [NN_W-1:0] rnd14(
    input logic signed [pwi_pkg::PROD_W-1:0] p
  );
    logic signed [pwi_pkg::PROD_W:0] t;
    t = {p[pwi_pkg::PROD_W-1], p};
    t = t + (pwi_pkg::PROD_W + 1)'(8192);
    return NN_W'(t >>> 14);
  endfunction

  function automatic logic signed [U_W-1:0] rnd15(
    input logic signed [pwi_pkg::PROD_W-1:0] p
  );
    logic signed [pwi_pkg::PROD_W:0] t;
    t = {p[pwi_pkg::PROD_W-1], p};
    t = t + (pwi_pkg::PROD_W + 1)'(16384);
    return U_W'(t >>> 15);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [U_W:0] s);
    logic [31:0] r;
    if ((s[U_W:31] == '0) || (s[U_W:31] == '1)) begin
      r = s[31:0];
    end else if (s[U_W]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic [1:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [1:0]  mode_q;
  logic [15:0] rest_q;
  logic [15:0] fric_q;

  logic [1:0]  kind_q, kind_d;
  logic        active_q, active_d;
  logic        clear_q, clear_d;

  logic signed [U_W-1:0]           u_q[3], u_d[3];
  logic signed [pwi_pkg::NRM_W-1:0] n_q[3], n_d[3];
  logic signed [pwi_pkg::VEL_W-1:0] w_q[3], w_d[3];
  logic signed [NN_W-1:0]          nn_q[3], nn_d[3];
  logic signed [NN_W-1:0]          ut_q[3], ut_d[3];
  logic signed [DOT_W-1:0]         un30_q, un30_d;

  logic signed [pwi_pkg::VEL_W-1:0] vin[3];
  logic signed [pwi_pkg::VEL_W-1:0] win[3];
  logic signed [pwi_pkg::NRM_W-1:0] nin[3];

  logic        out_valid_q, out_valid_d;
  logic        handled_q, handled_d;
  logic        keep_q, keep_d;
  logic        act_out_q, act_out_d;
  logic [31:0] vel_out_q[3], vel_out_d[3];
  logic [31:0] esc_tot_q, esc_tot_d;
  logic [31:0] stk_tot_q, stk_tot_d;
  logic [31:0] esc_cnt_q, esc_cnt_d;
  logic [31:0] stk_cnt_q, stk_cnt_d;

  pwi_pkg::mul_tag_t                    iss_tag;
  pwi_pkg::mul_tag_t                    res_tag;
  logic signed [pwi_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [pwi_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [pwi_pkg::PROD_W-1:0]    prod;
  logic signed [pwi_pkg::MUL_A_W-1:0]   un_a;
  logic signed [DOT_W:0]                un_t;
  logic [16:0]                          fac;
  logic                                 accept;
  logic                                 load_out;
  logic signed [U_W:0]                  vsum;
  logic [31:0]                          esc_new, stk_new;

  assign vin = '{vel_x_i, vel_y_i, vel_z_i};
  assign win = '{wall_vel_x_i, wall_vel_y_i, wall_vel_z_i};
  assign nin = '{normal_x_i, normal_y_i, normal_z_i};

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign fac        = 17'(rest_q) + 17'd32768;

  assign un_t = {un30_q[DOT_W-1], un30_q} + (DOT_W + 1)'(8192);
  assign un_a = pwi_pkg::MUL_A_W'(un_t >>> 14);

  // Issue schedule of the shared multiplier.
  always_comb begin
    iss_tag = '0;
    if (state_q == ST_CALC) begin
      iss_tag.vld = 1'b1;
      case (step_q)
        4'd0:  begin iss_tag.grp = pwi_pkg::GRP_DOT;  iss_tag.lane = 2'd0; end
        4'd1:  begin iss_tag.grp = pwi_pkg::GRP_DOT;  iss_tag.lane = 2'd1; end
        4'd2:  begin iss_tag.grp = pwi_pkg::GRP_DOT;  iss_tag.lane = 2'd2; end
        4'd4:  begin iss_tag.grp = pwi_pkg::GRP_PROJ; iss_tag.lane = 2'd0; end
        4'd5:  begin iss_tag.grp = pwi_pkg::GRP_PROJ; iss_tag.lane = 2'd1; end
        4'd6:  begin iss_tag.grp = pwi_pkg::GRP_PROJ; iss_tag.lane = 2'd2; end
        4'd7:  begin iss_tag.grp = pwi_pkg::GRP_REST; iss_tag.lane = 2'd0; end
        4'd8:  begin iss_tag.grp = pwi_pkg::GRP_REST; iss_tag.lane = 2'd1; end
        4'd9:  begin iss_tag.grp = pwi_pkg::GRP_REST; iss_tag.lane = 2'd2; end
        4'd10: begin iss_tag.grp = pwi_pkg::GRP_FRIC; iss_tag.lane = 2'd0; end
        4'd11: begin iss_tag.grp = pwi_pkg::GRP_FRIC; iss_tag.lane = 2'd1; end
        4'd12: begin iss_tag.grp = pwi_pkg::GRP_FRIC; iss_tag.lane = 2'd2; end
        default: iss_tag.vld = 1'b0;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    for (int i = 0; i < 3; i++) begin
      if (iss_tag.lane == 2'(i)) begin
        case (iss_tag.grp)
          pwi_pkg::GRP_DOT: begin
            mul_a = pwi_pkg::MUL_A_W'(u_q[i]);
            mul_b = pwi_pkg::MUL_B_W'(n_q[i]);
          end
          pwi_pkg::GRP_PROJ: begin
            mul_a = un_a;
            mul_b = pwi_pkg::MUL_B_W'(n_q[i]);
          end
          pwi_pkg::GRP_REST: begin
            mul_a = pwi_pkg::MUL_A_W'(nn_q[i]);
            mul_b = pwi_pkg::MUL_B_W'(fac);
          end
          default: begin
            mul_a = pwi_pkg::MUL_A_W'(ut_q[i]);
            mul_b = pwi_pkg::MUL_B_W'(fric_q);
          end
        endcase
      end
    end
  end

  pwi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (iss_tag),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_o  (res_tag),
    .prod_o (prod)
  );

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    kind_d   = kind_q;
    active_d = active_q;
    clear_d  = clear_q;
    u_d      = u_q;
    n_d      = n_q;
    w_d      = w_q;
    nn_d     = nn_q;
    ut_d     = ut_q;
    un30_d   = un30_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            u_d[i] = U_W'(vin[i]) - U_W'(win[i]);
            n_d[i] = nin[i];
            w_d[i] = win[i];
          end
          un30_d   = '0;
          step_d   = '0;
          active_d = active_in_i;
          clear_d  = clear_counts_i;
          if (!is_wall_i) begin
            kind_d = KIND_PASS;
          end else begin
            case (mode_q)
              pwi_pkg::MODE_ESCAPE:  kind_d = KIND_ESC;
              pwi_pkg::MODE_STICK:   kind_d = KIND_STICK;
              pwi_pkg::MODE_REBOUND: kind_d = KIND_REB;
              default:               kind_d = KIND_PASS;
            endcase
          end
          if (is_wall_i && (mode_q == pwi_pkg::MODE_REBOUND)) begin
            state_d = ST_CALC;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CALC: begin
        step_d = step_q + 4'd1;
        if (step_q == STEP_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (res_tag.vld) begin
      for (int i = 0; i < 3; i++) begin
        if (res_tag.lane == 2'(i)) begin
          case (res_tag.grp)
            pwi_pkg::GRP_DOT: begin
              un30_d = un30_q + DOT_W'(prod);
            end
            pwi_pkg::GRP_PROJ: begin
              nn_d[i] = rnd14(prod);
              ut_d[i] = NN_W'(u_q[i]) - rnd14(prod);
            end
            pwi_pkg::GRP_REST: begin
              if (un30_q > 0) begin
                u_d[i] = u_q[i] - rnd15(prod);
              end
            end
            default: begin
              u_d[i] = u_q[i] - rnd15(prod);
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    handled_d   = handled_q;
    keep_d      = keep_q;
    act_out_d   = act_out_q;
    vel_out_d   = vel_out_q;
    esc_tot_d   = esc_tot_q;
    stk_tot_d   = stk_tot_q;
    esc_cnt_d   = esc_cnt_q;
    stk_cnt_d   = stk_cnt_q;
    vsum        = '0;
    esc_new     = esc_cnt_q + {31'b0, (kind_q == KIND_ESC)};
    stk_new     = stk_cnt_q + {31'b0, (kind_q == KIND_STICK)};

    if (load_out) begin
      out_valid_d = 1'b1;
      handled_d   = (kind_q != KIND_PASS);
      keep_d      = (kind_q != KIND_ESC);
      act_out_d   = (kind_q == KIND_REB) || ((kind_q == KIND_PASS) && active_q);
      for (int i = 0; i < 3; i++) begin
        vsum = (U_W + 1)'(u_q[i]) + (U_W + 1)'(w_q[i]);
        if ((kind_q == KIND_PASS) || (kind_q == KIND_REB)) begin
          vel_out_d[i] = sat32(vsum);
        end else begin
          vel_out_d[i] = '0;
        end
      end
      esc_tot_d = esc_new;
      stk_tot_d = stk_new;
      esc_cnt_d = clear_q ? '0 : esc_new;
      stk_cnt_d = clear_q ? '0 : stk_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mode_q      <= pwi_pkg::MODE_REBOUND;
      rest_q      <= 16'd32768;
      fric_q      <= '0;
      out_valid_q <= 1'b0;
      esc_cnt_q   <= '0;
      stk_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      esc_cnt_q   <= esc_cnt_d;
      stk_cnt_q   <= stk_cnt_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pwi_pkg::REG_MODE:        mode_q <= cfg_wdata_i[1:0];
          pwi_pkg::REG_RESTITUTION: rest_q <= cfg_wdata_i;
          pwi_pkg::REG_FRICTION:    fric_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    active_q  <= active_d;
    clear_q   <= clear_d;
    u_q       <= u_d;
    n_q       <= n_d;
    w_q       <= w_d;
    nn_q      <= nn_d;
    ut_q      <= ut_d;
    un30_q    <= un30_d;
    handled_q <= handled_d;
    keep_q    <= keep_d;
    act_out_q <= act_out_d;
    vel_out_q <= vel_out_d;
    esc_tot_q <= esc_tot_d;
    stk_tot_q <= stk_tot_d;
  end

  assign out_valid_o     = out_valid_q;
  assign handled_o       = handled_q;
  assign keep_particle_o = keep_q;
  assign active_out_o    = act_out_q;
  assign out_vel_x_o     = vel_out_q[0];
  assign out_vel_y_o     = vel_out_q[1];
  assign out_vel_z_o     = vel_out_q[2];
  assign escape_total_o  = esc_tot_q;
  assign stick_total_o   = stk_tot_q;

  // Products only return while a rebound is being worked out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_tag.vld |-> (state_q == ST_CALC))
    else $error("multiplier result outside the rebound sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> ((kind_q == KIND_REB) && (step_q <= STEP_LAST)))
    else $error("sequencer running for a non-rebound request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_wall_i && (mode_q == pwi_pkg::MODE_REBOUND)) |=> (state_q == ST_CALC))
    else $error("rebound request did not start the sequencer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result appeared without a finished request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !handled_o) |-> keep_particle_o)
    else $error("unhandled hit dropped the particle");

endmodule

`default_nettype wire

/* rtl/core/pwi_mul.sv */
// Shared signed multiplier with a registered product and operation tag.
`default_nettype none

module pwi_mul (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire pwi_pkg::mul_tag_t                 tag_i,
  input  wire logic signed [pwi_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [pwi_pkg::MUL_B_W-1:0] b_i,
  output pwi_pkg::mul_tag_t                      tag_o,
  output logic signed [pwi_pkg::PROD_W-1:0]      prod_o
);

  pwi_pkg::mul_tag_t                   tag_q;
  logic signed [pwi_pkg::PROD_W-1:0]   prod_q;
  logic signed [pwi_pkg::PROD_W-1:0]   prod_d;

  assign prod_d = pwi_pkg::PROD_W'(a_i) * pwi_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign tag_o  = tag_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* sim/particle_wall_interaction_tb.sv */
// Self-checking testbench for the particle-wall hit resolver, with a built-in rebound predictor.
module particle_wall_interaction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwi_pkg::*;

  localparam logic [1:0] MODE_PASS = 2'd3;
  localparam logic [COEF_W-1:0] COEF_ONE = 16'd32768;
  localparam logic signed [VEL_W-1:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [VEL_W-1:0] VMIN = 32'sh8000_0000;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic                    wall;
    logic                    act;
    logic signed [VEL_W-1:0] vx, vy, vz;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic signed [VEL_W-1:0] wx, wy, wz;
    logic                    clr;
  } hit_t;

  typedef struct packed {
    logic                    handled;
    logic                    keep;
    logic                    act;
    logic signed [VEL_W-1:0] vx, vy, vz;
    logic [31:0]             esc;
    logic [31:0]             stk;
  } res_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [COEF_W-1:0] rest;
    logic [COEF_W-1:0] fric;
    hit_t              hit;
    logic              chk;
    res_t              res;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [CFG_IDX_W-1:0]           cfg_addr_i;
  logic [COEF_W-1:0]              cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           is_wall_i;
  logic                           active_in_i;
  logic signed [VEL_W-1:0]        vel_x_i, vel_y_i, vel_z_i;
  logic signed [NRM_W-1:0]        normal_x_i, normal_y_i, normal_z_i;
  logic signed [VEL_W-1:0]        wall_vel_x_i, wall_vel_y_i, wall_vel_z_i;
  logic                           clear_counts_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           handled_o;
  logic                           keep_particle_o;
  logic                           active_out_o;
  logic signed [VEL_W-1:0]        out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic [31:0]                    escape_total_o;
  logic [31:0]                    stick_total_o;

  particle_wall_interaction dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .is_wall_i, .active_in_i,
    .vel_x_i, .vel_y_i, .vel_z_i, .normal_x_i, .normal_y_i, .normal_z_i,
    .wall_vel_x_i, .wall_vel_y_i, .wall_vel_z_i, .clear_counts_i,
    .out_valid_o, .out_ready_i, .handled_o, .keep_particle_o, .active_out_o,
    .out_vel_x_o, .out_vel_y_o, .out_vel_z_o, .escape_total_o, .stick_total_o
  );

  // Register shadow and hit counters of the predictor.
  logic [1:0]        mode_r;
  logic [COEF_W-1:0] rest_r;
  logic [COEF_W-1:0] fric_r;
  logic [31:0]       esc_cnt;
  logic [31:0]       stk_cnt;

  res_t     pending_results[$];
  dir_row_t directed_hits[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  n_errors = 0;
  int  n_checked = 0;
  int  n_sent = 0;
  int  n_settings = 0;
  int  n_holds = 0;
  int  n_rebound = 0, n_escape = 0, n_stick = 0, n_pass = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_vel(input longint x);
    if (x > longint'(VMAX)) return VMAX;
    if (x < longint'(VMIN)) return VMIN;
    return x[VEL_W-1:0];
  endfunction

  // Resolves one hit against the current register shadow and advances the counters.
  function automatic res_t resolve_hit(input hit_t h);
    res_t   r;
    longint vel[3], nrm[3], wv[3], u[3], nn[3], ut[3];
    longint dot, un, fac;
    vel[0] = $signed(h.vx); vel[1] = $signed(h.vy); vel[2] = $signed(h.vz);
    nrm[0] = $signed(h.nx); nrm[1] = $signed(h.ny); nrm[2] = $signed(h.nz);
    wv[0] = $signed(h.wx); wv[1] = $signed(h.wy); wv[2] = $signed(h.wz);
    r.handled = 1'b0;
    r.keep = 1'b1;
    r.act = h.act;
    r.vx = h.vx;
    r.vy = h.vy;
    r.vz = h.vz;
    if (h.wall && mode_r == MODE_ESCAPE) begin
      r.handled = 1'b1;
      r.keep = 1'b0;
      r.act = 1'b0;
      r.vx = '0;
      r.vy = '0;
      r.vz = '0;
      esc_cnt = esc_cnt + 1;
      n_escape++;
    end else if (h.wall && mode_r == MODE_STICK) begin
      r.handled = 1'b1;
      r.act = 1'b0;
      r.vx = '0;
      r.vy = '0;
      r.vz = '0;
      stk_cnt = stk_cnt + 1;
      n_stick++;
    end else if (h.wall && mode_r == MODE_REBOUND) begin
      r.handled = 1'b1;
      r.act = 1'b1;
      fac = 32768 + longint'(rest_r);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        u[i] = vel[i] - wv[i];
        dot += u[i] * nrm[i];
      end
      un = round_shift(dot, 14);
      for (int i = 0; i < 3; i++) begin
        nn[i] = round_shift(un * nrm[i], 14);
        ut[i] = u[i] - nn[i];
        if (dot > 0) u[i] -= round_shift(fac * nn[i], 15);
        u[i] -= round_shift(longint'(fric_r) * ut[i], 15);
      end
      r.vx = clamp_vel(u[0] + wv[0]);
      r.vy = clamp_vel(u[1] + wv[1]);
      r.vz = clamp_vel(u[2] + wv[2]);
      n_rebound++;
    end else begin
      n_pass++;
    end
    r.esc = esc_cnt;
    r.stk = stk_cnt;
    if (h.clr) begin
      esc_cnt = '0;
      stk_cnt = '0;
    end
    return r;
  endfunction

  function automatic hit_t mk_hit(input logic wall, input logic act,
                                  input logic signed [VEL_W-1:0] vx, vy, vz,
                                  input logic signed [NRM_W-1:0] nx, ny, nz,
                                  input logic signed [VEL_W-1:0] wx, wy, wz,
                                  input logic clr);
    return '{wall, act, vx, vy, vz, nx, ny, nz, wx, wy, wz, clr};
  endfunction

  function automatic res_t mk_res(input logic handled, input logic keep, input logic act,
                                  input logic signed [VEL_W-1:0] vx, vy, vz,
                                  input logic [31:0] esc, input logic [31:0] stk);
    return '{handled, keep, act, vx, vy, vz, esc, stk};
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic [COEF_W-1:0] rest, fric,
                         input hit_t h, input logic chk, input res_t res);
    directed_hits.push_back('{mode, rest, fric, h, chk, res});
  endtask

  function automatic logic signed [VEL_W-1:0] rand_vel();
    case ($urandom_range(7))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return VMAX;
          1: return VMIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return int'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic signed [NRM_W-1:0] rand_nrm();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(7))
      0: return bits[NRM_W-1:0];
      1: return bits[0] ? 16'sd16384 : -16'sd16384;
      2: return '0;
      default: return int'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    h.wall = ($urandom_range(9) != 0);
    h.act = $urandom_range(1);
    h.vx = rand_vel();
    h.vy = rand_vel();
    h.vz = rand_vel();
    h.nx = rand_nrm();
    h.ny = rand_nrm();
    h.nz = rand_nrm();
    h.wx = $urandom_range(1) ? rand_vel() : '0;
    h.wy = $urandom_range(1) ? rand_vel() : '0;
    h.wz = $urandom_range(1) ? rand_vel() : '0;
    h.clr = ($urandom_range(19) == 0);
    return h;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 30)
      $display("%0t: result %0d, %s is %h, expected %h", $realtime, n_checked, what, got, want);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [COEF_W-1:0] rest, fric);
    in_valid_i = 1'b0;
    drain_results();
    cfg_we_i = 1'b1;
    cfg_addr_i = REG_MODE;
    cfg_wdata_i = {{(COEF_W-2){1'b0}}, mode};
    @(negedge clk_i);
    cfg_addr_i = REG_RESTITUTION;
    cfg_wdata_i = rest;
    @(negedge clk_i);
    cfg_addr_i = REG_FRICTION;
    cfg_wdata_i = fric;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mode_r = mode;
    rest_r = rest;
    fric_r = fric;
    n_settings++;
  endtask

  // Offers one request, waits for it to be taken and records what it should produce.
  task automatic send_hit(input hit_t h, input logic chk, input res_t typed);
    res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    is_wall_i = h.wall;
    active_in_i = h.act;
    vel_x_i = h.vx;
    vel_y_i = h.vy;
    vel_z_i = h.vz;
    normal_x_i = h.nx;
    normal_y_i = h.ny;
    normal_z_i = h.nz;
    wall_vel_x_i = h.wx;
    wall_vel_y_i = h.wy;
    wall_vel_z_i = h.wz;
    clear_counts_i = h.clr;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = resolve_hit(h);
    pending_results.push_back(chk ? typed : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, handled", handled_o, 'x);
      end else begin
        want = pending_results.pop_front();
        if (handled_o !== want.handled) report_mismatch("handled", handled_o, want.handled);
        if (keep_particle_o !== want.keep) report_mismatch("keep", keep_particle_o, want.keep);
        if (active_out_o !== want.act) report_mismatch("active", active_out_o, want.act);
        if (out_vel_x_o !== want.vx) report_mismatch("vel x", out_vel_x_o, want.vx);
        if (out_vel_y_o !== want.vy) report_mismatch("vel y", out_vel_y_o, want.vy);
        if (out_vel_z_o !== want.vz) report_mismatch("vel z", out_vel_z_o, want.vz);
        if (escape_total_o !== want.esc) report_mismatch("escapes", escape_total_o, want.esc);
        if (stick_total_o !== want.stk) report_mismatch("sticks", stick_total_o, want.stk);
        n_checked++;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        n_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("No request moved for %0d cycles, %0d results outstanding.",
             QUIET_LIMIT, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    dir_row_t row;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    is_wall_i = 1'b0;
    active_in_i = 1'b0;
    vel_x_i = '0;
    vel_y_i = '0;
    vel_z_i = '0;
    normal_x_i = '0;
    normal_y_i = '0;
    normal_z_i = '0;
    wall_vel_x_i = '0;
    wall_vel_y_i = '0;
    wall_vel_z_i = '0;
    clear_counts_i = 1'b0;
    mode_r = MODE_REBOUND;
    rest_r = COEF_ONE;
    fric_r = '0;
    esc_cnt = '0;
    stk_cnt = '0;

    // Non-wall patches pass through untouched.
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(0, 1, VMIN, VMAX, 0, 16384, -16384, 0, VMAX, VMIN, 1, 0),
            1, mk_res(0, 1, 1, VMIN, VMAX, 0, 0, 0));
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(0, 0, -1, 1, VMIN, -32768, 32767, 0, 0, 0, 0, 0),
            1, mk_res(0, 1, 0, -1, 1, VMIN, 0, 0));
    // Head-on approach, receding particle and a grazing hit with e = 1.
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(1, 1, 65536, 0, 131072, 0, 0, 16384, 0, 0, 0, 0),
            1, mk_res(1, 1, 1, 65536, 0, -131072, 0, 0));
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(1, 0, 0, 0, -131072, 0, 0, 16384, 0, 0, 0, 0),
            1, mk_res(1, 1, 1, 0, 0, -131072, 0, 0));
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(1, 1, 65536, 0, 0, 0, 0, 16384, 0, 0, 0, 0),
            1, mk_res(1, 1, 1, 65536, 0, 0, 0, 0));
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(1, 1, VMAX, VMAX, VMAX, 16384, 16384, 16384, VMIN, VMIN, VMIN, 0), 0, '0);
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(1, 1, VMIN, VMIN, VMIN, -32768, 32767, -16384, VMAX, VMAX, VMAX, 0), 0, '0);
    add_row(MODE_REBOUND, COEF_ONE, 0,
            mk_hit(1, 1, 3000000, -7000000, 12345678, 9459, 9459, -9459, 65536, -32768, 4096, 0),
            0, '0);
    // No restitution and full friction bring the particle to rest.
    add_row(MODE_REBOUND, 0, COEF_ONE,
            mk_hit(1, 1, 65536, 0, 131072, 0, 0, 16384, 0, 0, 0, 0),
            1, mk_res(1, 1, 1, 0, 0, 0, 0, 0));
    add_row(MODE_REBOUND, 0, COEF_ONE,
            mk_hit(1, 1, -500000, 800000, 250000, -11585, 11585, 0, 100000, -20000, 0, 0), 0, '0);
    add_row(MODE_REBOUND, 16'hffff, 16'hffff,
            mk_hit(1, 1, VMAX, VMIN, 1234567, 16384, -16384, 16384, -65536, 65536, 0, 0), 0, '0);
    add_row(MODE_ESCAPE, COEF_ONE, 0,
            mk_hit(1, 1, 65536, 65536, 65536, 0, 16384, 0, 0, 0, 0, 0),
            1, mk_res(1, 0, 0, 0, 0, 0, 1, 0));
    add_row(MODE_ESCAPE, COEF_ONE, 0,
            mk_hit(1, 0, VMIN, VMAX, -1, 0, 0, -16384, 5, 5, 5, 0),
            1, mk_res(1, 0, 0, 0, 0, 0, 2, 0));
    add_row(MODE_ESCAPE, COEF_ONE, 0,
            mk_hit(0, 1, 777, -777, 0, 0, 0, 16384, 0, 0, 0, 0),
            1, mk_res(0, 1, 1, 777, -777, 0, 2, 0));
    add_row(MODE_ESCAPE, COEF_ONE, 0,
            mk_hit(1, 1, 1, 2, 3, 16384, 0, 0, 0, 0, 0, 1),
            1, mk_res(1, 0, 0, 0, 0, 0, 3, 0));
    add_row(MODE_ESCAPE, COEF_ONE, 0,
            mk_hit(1, 1, 4, 5, 6, 16384, 0, 0, 0, 0, 0, 0),
            1, mk_res(1, 0, 0, 0, 0, 0, 1, 0));
    add_row(MODE_STICK, COEF_ONE, 0,
            mk_hit(1, 1, 65536, -65536, 0, 0, 16384, 0, 0, 0, 0, 0),
            1, mk_res(1, 1, 0, 0, 0, 0, 1, 1));
    add_row(MODE_STICK, COEF_ONE, 0,
            mk_hit(1, 0, VMAX, VMAX, VMAX, 0, -16384, 0, 0, 0, 0, 0),
            1, mk_res(1, 1, 0, 0, 0, 0, 1, 2));
    add_row(MODE_STICK, COEF_ONE, 0,
            mk_hit(0, 0, 9, 8, 7, 0, 0, 0, 0, 0, 0, 1),
            1, mk_res(0, 1, 0, 9, 8, 7, 1, 2));
    add_row(MODE_STICK, COEF_ONE, 0,
            mk_hit(1, 1, 9, 8, 7, 16384, 0, 0, 0, 0, 0, 0),
            1, mk_res(1, 1, 0, 0, 0, 0, 0, 1));
    // The unused mode value leaves wall hits unhandled and the counters alone.
    add_row(MODE_PASS, COEF_ONE, 0,
            mk_hit(1, 1, 100, -200, 300, 0, 0, 16384, 1, 1, 1, 0),
            1, mk_res(0, 1, 1, 100, -200, 300, 0, 1));
    add_row(MODE_PASS, COEF_ONE, 0,
            mk_hit(1, 0, VMIN, 0, VMAX, 0, 0, 16384, 0, 0, 0, 1),
            1, mk_res(0, 1, 0, VMIN, 0, VMAX, 0, 1));
    add_row(MODE_REBOUND, 16384, 8192,
            mk_hit(1, 1, 2000000, -3000000, -4000000, 0, 11585, -11585, -100000, 50000, 0, 0),
            0, '0);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_hits[i]) begin
      row = directed_hits[i];
      if (row.mode != mode_r || row.rest != rest_r || row.fric != fric_r)
        set_config(row.mode, row.rest, row.fric);
      send_hit(row.hit, row.chk, row.res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_config(MODE_REBOUND, COEF_ONE, 0);
        1: set_config(MODE_REBOUND, 0, COEF_ONE);
        2: set_config(MODE_ESCAPE, $urandom_range(32768), $urandom_range(32768));
        3: set_config(MODE_STICK, $urandom_range(32768), $urandom_range(32768));
        5: set_config(MODE_PASS, $urandom_range(32768), $urandom_range(32768));
        6: set_config(MODE_REBOUND, 16'hffff, 16'hffff);
        7: set_config($urandom_range(3), $urandom_range(16'hffff), $urandom_range(16'hffff));
        default: set_config(MODE_REBOUND, $urandom_range(32768), $urandom_range(32768));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 4 && k == 20) hold_req = 1'b1;
        send_hit(rand_hit(), 1'b0, '0);
      end
    end

    in_valid_i = 1'b0;
    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d hits under %0d register settings: %0d rebound, %0d escape, %0d stick,",
             n_sent, n_settings, n_rebound, n_escape, n_stick);
    $display("%0d passed through; %0d results compared, %0d long output stalls, %0d mismatches.",
             n_pass, n_checked, n_holds, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pwi_pkg.sv
rtl/core/pwi_mul.sv
rtl/core/particle_wall_interaction.sv
sim/particle_wall_interaction_tb.sv
